// ===== rtl/rpam_pkg.sv =====
// Shared constants, types and codes for the read pair allele merge block.
// Depends on nothing; all other files but rpam_ram refer to it by scoped names.
`timescale 1ns / 1ps

package rpam_pkg;

    localparam int MAX_ALLELES = 32;
    localparam int IDX_W       = 28;
    localparam int CODE_W      = 8;
    localparam int QUAL_W      = 8;
    localparam int ENTRY_W     = IDX_W + CODE_W + QUAL_W;
    localparam int OP_W        = 2;
    localparam int KIND_W      = 3;
    localparam int RUN_W       = 7;

    localparam int LIST_AW     = $clog2(MAX_ALLELES);
    localparam int CNT_W       = $clog2(MAX_ALLELES + 1);
    localparam int MERGE_DEPTH = 2 * MAX_ALLELES;
    localparam int MERGE_AW    = $clog2(MERGE_DEPTH);
    localparam int MCNT_W      = $clog2(MERGE_DEPTH + 1);

    localparam logic [OP_W-1:0] OP_APPEND_FIRST  = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND_SECOND = 2'd1;
    localparam logic [OP_W-1:0] OP_PROCESS       = 2'd2;

    typedef enum logic [KIND_W-1:0] {
        KIND_FIRST_SECOND = 3'd0,
        KIND_SECOND_FIRST = 3'd1,
        KIND_MERGED       = 3'd2,
        KIND_FIRST_ALONE  = 3'd3,
        KIND_NONE         = 3'd4
    } kind_t;

    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [CODE_W-1:0] code;
        logic [QUAL_W-1:0] qual;
    } entry_t;

    typedef struct packed {
        logic load_first;
        logic load_second;
        logic walk_start;
        logic walk_step;
        logic clear_counts;
        logic emit_start;
        logic emit_fire;
        logic emit_none;
    } dp_cmd_t;

    typedef struct packed {
        kind_t cls;
        logic  walk_done;
        logic  emit_ok;
        logic  emit_last;
        logic  out_free;
    } dp_status_t;

endpackage

// ===== rtl/rpam_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// Standalone; used for the two read lists and the merged list.
`timescale 1ns / 1ps

module rpam_ram #(
    parameter int WIDTH = 44,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/rpam_ctrl.sv =====
// Controller for the read pair allele merge block: sequences loading,
// the list walk and the result emission. Depends on rpam_pkg.
`timescale 1ns / 1ps

module rpam_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [rpam_pkg::OP_W-1:0]    op,
    input  rpam_pkg::dp_status_t         status,
    output rpam_pkg::dp_cmd_t            cmd,
    output logic                         in_stall
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_EMIT,
        ST_NONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (op)
                        rpam_pkg::OP_APPEND_FIRST:  cmd.load_first  = 1'b1;
                        rpam_pkg::OP_APPEND_SECOND: cmd.load_second = 1'b1;
                        rpam_pkg::OP_PROCESS:
                        begin
                            if (status.cls == rpam_pkg::KIND_NONE)
                            begin
                                cmd.clear_counts = 1'b1;
                                state_next       = ST_NONE;
                            end
                            else
                            begin
                                cmd.walk_start = 1'b1;
                                state_next     = ST_WALK;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_WALK:
            begin
                cmd.walk_step = 1'b1;
                if (status.walk_done)
                begin
                    // The counts are no longer needed once the merged list is built.
                    cmd.clear_counts = 1'b1;
                    cmd.emit_start   = 1'b1;
                    state_next       = status.emit_ok ? ST_EMIT : ST_NONE;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_fire = 1'b1;
                    if (status.emit_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_NONE:
            begin
                if (status.out_free)
                begin
                    cmd.emit_none = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

endmodule

// ===== rtl/rpam_dp.sv =====
// Datapath for the read pair allele merge block: list memories, counts,
// classification, merge walk, run counting and the output register.
// Depends on rpam_pkg and rpam_ram.
`timescale 1ns / 1ps

module rpam_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rpam_pkg::dp_cmd_t             cmd,
    output rpam_pkg::dp_status_t          status,
    input  logic [rpam_pkg::IDX_W-1:0]    variant_index,
    input  logic [rpam_pkg::CODE_W-1:0]   allele_code,
    input  logic [rpam_pkg::QUAL_W-1:0]   quality,
    input  logic                          cfg_valid,
    input  logic                          cfg_single_reads,
    input  logic                          out_stall,
    output logic                          out_valid,
    output logic [rpam_pkg::KIND_W-1:0]   kind,
    output logic [rpam_pkg::IDX_W-1:0]    variant_index_res,
    output logic [rpam_pkg::CODE_W-1:0]   allele_code_res,
    output logic [rpam_pkg::QUAL_W-1:0]   quality_res,
    output logic [rpam_pkg::RUN_W-1:0]    run_count,
    output logic                          last
);

    localparam int CNT_W  = rpam_pkg::CNT_W;
    localparam int MCNT_W = rpam_pkg::MCNT_W;
    localparam int IDX_W  = rpam_pkg::IDX_W;

    // Control state
    logic                  sre_reg;
    logic [CNT_W-1:0]      cnt1_reg, cnt1_next;
    logic [CNT_W-1:0]      cnt2_reg, cnt2_next;
    logic                  out_valid_reg, out_valid_next;

    // Walk and emit state
    rpam_pkg::kind_t       mode_reg, mode_next;
    logic [CNT_W-1:0]      j_reg, j_next;
    logic [CNT_W-1:0]      k_reg, k_next;
    logic [MCNT_W-1:0]     m_reg, m_next;
    logic [MCNT_W-1:0]     runs_reg, runs_next;
    logic [MCNT_W-1:0]     e_reg, e_next;
    logic [IDX_W-1:0]      prev_idx_reg, prev_idx_next;
    logic [IDX_W-1:0]      head1_reg, head1_next, tail1_reg, tail1_next;
    logic [IDX_W-1:0]      head2_reg, head2_next, tail2_reg, tail2_next;

    // Output payload
    rpam_pkg::kind_t       out_kind_reg, out_kind_next;
    rpam_pkg::entry_t      out_entry_reg, out_entry_next;
    logic [MCNT_W-1:0]     out_runs_reg, out_runs_next;
    logic                  out_last_reg, out_last_next;

    // Memory ports
    rpam_pkg::entry_t      in_entry;
    logic                  wr1_en, wr2_en;
    logic [rpam_pkg::ENTRY_W-1:0] rd1_data, rd2_data, rdm_data;
    rpam_pkg::entry_t      a_ent, b_ent, m_ent;

    // Walk decision
    logic [CNT_W-1:0]      n2_eff;
    logic                  a_ok, b_ok, done;
    logic                  take_a, take_b, take_both, adv_a, adv_b;
    logic                  wr_m_en;
    rpam_pkg::entry_t      wr_m_entry;
    logic [IDX_W:0]        prev_inc;
    logic                  run_break;
    logic [CNT_W:0]        total;
    rpam_pkg::kind_t       cls;
    logic                  out_free;

    assign in_entry.idx  = variant_index;
    assign in_entry.code = allele_code;
    assign in_entry.qual = quality;

    assign wr1_en = cmd.load_first  && (cnt1_reg < CNT_W'(rpam_pkg::MAX_ALLELES));
    assign wr2_en = cmd.load_second && (cnt2_reg < CNT_W'(rpam_pkg::MAX_ALLELES));

    // The read addresses follow the next walk position, so the read data
    // always belongs to the current position.
    rpam_ram #(
        .WIDTH (rpam_pkg::ENTRY_W),
        .DEPTH (rpam_pkg::MAX_ALLELES)
    ) u_first_list (
        .clk     (clk),
        .wr_en   (wr1_en),
        .wr_addr (cnt1_reg[rpam_pkg::LIST_AW-1:0]),
        .wr_data (in_entry),
        .rd_addr (j_next[rpam_pkg::LIST_AW-1:0]),
        .rd_data (rd1_data)
    );

    rpam_ram #(
        .WIDTH (rpam_pkg::ENTRY_W),
        .DEPTH (rpam_pkg::MAX_ALLELES)
    ) u_second_list (
        .clk     (clk),
        .wr_en   (wr2_en),
        .wr_addr (cnt2_reg[rpam_pkg::LIST_AW-1:0]),
        .wr_data (in_entry),
        .rd_addr (k_next[rpam_pkg::LIST_AW-1:0]),
        .rd_data (rd2_data)
    );

    rpam_ram #(
        .WIDTH (rpam_pkg::ENTRY_W),
        .DEPTH (rpam_pkg::MERGE_DEPTH)
    ) u_merged_list (
        .clk     (clk),
        .wr_en   (wr_m_en),
        .wr_addr (m_reg[rpam_pkg::MERGE_AW-1:0]),
        .wr_data (wr_m_entry),
        .rd_addr (e_next[rpam_pkg::MERGE_AW-1:0]),
        .rd_data (rdm_data)
    );

    assign a_ent = rd1_data;
    assign b_ent = rd2_data;
    assign m_ent = rdm_data;

    // Classification from the recorded ends of both lists.
    assign total = {1'b0, cnt1_reg} + {1'b0, cnt2_reg};

    always_comb
    begin
        if (cnt1_reg == '0 || cnt2_reg == '0)
        begin
            cls = rpam_pkg::KIND_NONE;
        end
        else if (tail1_reg < head2_reg)
        begin
            cls = rpam_pkg::KIND_FIRST_SECOND;
        end
        else if (tail2_reg < head1_reg)
        begin
            cls = rpam_pkg::KIND_SECOND_FIRST;
        end
        else if (total > (CNT_W + 1)'(2))
        begin
            cls = rpam_pkg::KIND_MERGED;
        end
        else if (sre_reg)
        begin
            cls = rpam_pkg::KIND_FIRST_ALONE;
        end
        else
        begin
            cls = rpam_pkg::KIND_NONE;
        end
    end

    // One walk step per cycle: copy an entry, merge or drop a pair.
    assign n2_eff = (mode_reg == rpam_pkg::KIND_FIRST_ALONE) ? '0 : cnt2_reg;
    assign a_ok   = (j_reg < cnt1_reg);
    assign b_ok   = (k_reg < n2_eff);
    assign done   = !a_ok && !b_ok;

    always_comb
    begin
        take_a    = 1'b0;
        take_b    = 1'b0;
        take_both = 1'b0;
        adv_a     = 1'b0;
        adv_b     = 1'b0;
        case (mode_reg)
            rpam_pkg::KIND_FIRST_SECOND:
            begin
                take_a = a_ok;
                take_b = !a_ok;
            end
            rpam_pkg::KIND_SECOND_FIRST:
            begin
                take_b = b_ok;
                take_a = !b_ok;
            end
            rpam_pkg::KIND_FIRST_ALONE:
            begin
                take_a = 1'b1;
            end
            rpam_pkg::KIND_MERGED:
            begin
                if (!a_ok)
                begin
                    take_b = 1'b1;
                end
                else if (!b_ok)
                begin
                    take_a = 1'b1;
                end
                else if (a_ent.idx < b_ent.idx)
                begin
                    take_a = 1'b1;
                end
                else if (a_ent.idx > b_ent.idx)
                begin
                    take_b = 1'b1;
                end
                else if (a_ent.code == b_ent.code)
                begin
                    take_both = 1'b1;
                end
                else
                begin
                    // Conflicting alleles at one index: both are dropped.
                    adv_a = 1'b1;
                    adv_b = 1'b1;
                end
            end
            default: ;
        endcase
        if (take_a || take_both)
        begin
            adv_a = 1'b1;
        end
        if (take_b || take_both)
        begin
            adv_b = 1'b1;
        end
    end

    always_comb
    begin
        wr_m_entry = a_ent;
        if (take_b)
        begin
            wr_m_entry = b_ent;
        end
        else if (take_both && (b_ent.qual > a_ent.qual))
        begin
            wr_m_entry.qual = b_ent.qual;
        end
    end

    assign wr_m_en   = cmd.walk_step && !done && (take_a || take_b || take_both);
    assign prev_inc  = {1'b0, prev_idx_reg} + (IDX_W + 1)'(1);
    assign run_break = ({1'b0, wr_m_entry.idx} != prev_inc);
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        cnt1_next      = cnt1_reg;
        cnt2_next      = cnt2_reg;
        head1_next     = head1_reg;
        tail1_next     = tail1_reg;
        head2_next     = head2_reg;
        tail2_next     = tail2_reg;
        mode_next      = mode_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        m_next         = m_reg;
        runs_next      = runs_reg;
        prev_idx_next  = prev_idx_reg;
        e_next         = e_reg;
        out_kind_next  = out_kind_reg;
        out_entry_next = out_entry_reg;
        out_runs_next  = out_runs_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && out_stall;

        if (wr1_en)
        begin
            cnt1_next  = cnt1_reg + CNT_W'(1);
            tail1_next = variant_index;
            if (cnt1_reg == '0)
            begin
                head1_next = variant_index;
            end
        end
        if (wr2_en)
        begin
            cnt2_next  = cnt2_reg + CNT_W'(1);
            tail2_next = variant_index;
            if (cnt2_reg == '0)
            begin
                head2_next = variant_index;
            end
        end
        if (cmd.clear_counts)
        begin
            cnt1_next = '0;
            cnt2_next = '0;
        end

        if (cmd.walk_start)
        begin
            mode_next = cls;
            j_next    = '0;
            k_next    = '0;
            m_next    = '0;
            runs_next = '0;
        end
        else if (cmd.walk_step && !done)
        begin
            if (adv_a)
            begin
                j_next = j_reg + CNT_W'(1);
            end
            if (adv_b)
            begin
                k_next = k_reg + CNT_W'(1);
            end
        end

        if (wr_m_en)
        begin
            m_next        = m_reg + MCNT_W'(1);
            prev_idx_next = wr_m_entry.idx;
            if (m_reg == '0 || run_break)
            begin
                runs_next = runs_reg + MCNT_W'(1);
            end
        end

        if (cmd.emit_start)
        begin
            e_next = '0;
        end
        else if (cmd.emit_fire)
        begin
            e_next         = e_reg + MCNT_W'(1);
            out_kind_next  = mode_reg;
            out_entry_next = m_ent;
            out_runs_next  = runs_reg;
            out_last_next  = (e_reg == m_reg - MCNT_W'(1));
            out_valid_next = 1'b1;
        end

        if (cmd.emit_none)
        begin
            out_kind_next  = rpam_pkg::KIND_NONE;
            out_entry_next = '0;
            out_runs_next  = '0;
            out_last_next  = 1'b1;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sre_reg       <= 1'b0;
            cnt1_reg      <= '0;
            cnt2_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                sre_reg <= cfg_single_reads;
            end
            cnt1_reg      <= cnt1_next;
            cnt2_reg      <= cnt2_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head1_reg     <= head1_next;
        tail1_reg     <= tail1_next;
        head2_reg     <= head2_next;
        tail2_reg     <= tail2_next;
        mode_reg      <= mode_next;
        j_reg         <= j_next;
        k_reg         <= k_next;
        m_reg         <= m_next;
        runs_reg      <= runs_next;
        prev_idx_reg  <= prev_idx_next;
        e_reg         <= e_next;
        out_kind_reg  <= out_kind_next;
        out_entry_reg <= out_entry_next;
        out_runs_reg  <= out_runs_next;
        out_last_reg  <= out_last_next;
    end

    assign status.cls       = cls;
    assign status.walk_done = done;
    assign status.emit_ok   = (mode_reg != rpam_pkg::KIND_MERGED) || (m_reg >= MCNT_W'(2));
    assign status.emit_last = (e_reg == m_reg - MCNT_W'(1));
    assign status.out_free  = out_free;

    assign out_valid         = out_valid_reg;
    assign kind              = out_kind_reg;
    assign variant_index_res = out_entry_reg.idx;
    assign allele_code_res   = out_entry_reg.code;
    assign quality_res       = out_entry_reg.qual;
    assign run_count         = rpam_pkg::RUN_W'(out_runs_reg);
    assign last              = out_last_reg;

endmodule

// ===== rtl/read_pair_allele_merge_unit.sv =====
// Top level of the read pair allele merge block: joins the controller and
// the datapath. Depends on rpam_pkg, rpam_ctrl and rpam_dp.
`timescale 1ns / 1ps
//
//  Channel   Direction  Handshake           Payload
//  in        sink       in_valid/in_stall   op, variant_index, allele_code, quality
//  cfg       sink       cfg_valid/cfg_ready single_reads_enable
//  out       source     out_valid/out_stall kind, variant_index_res, allele_code_res,
//                                           quality_res, run_count, last
//
// An append beat is taken without a stall and the next beat may follow at once.
// A process beat classifies the lists; unless the class is none, it walks the
// lists (one walk step per cycle through the single read port of each list
// memory), turns around and emits one result beat per cycle from the merged list
// memory while out is not stalled, or a single none beat when no list is emitted.
// A stall on out holds the result register and pauses emission; in is stalled
// from the process beat until its last result is loaded into the register.
// Reset clears the counts, the enable register and the output valid; the list
// memories are not cleared.

module read_pair_allele_merge_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [rpam_pkg::OP_W-1:0]     op,
    input  logic [rpam_pkg::IDX_W-1:0]    variant_index,
    input  logic [rpam_pkg::CODE_W-1:0]   allele_code,
    input  logic [rpam_pkg::QUAL_W-1:0]   quality,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          single_reads_enable,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [rpam_pkg::KIND_W-1:0]   kind,
    output logic [rpam_pkg::IDX_W-1:0]    variant_index_res,
    output logic [rpam_pkg::CODE_W-1:0]   allele_code_res,
    output logic [rpam_pkg::QUAL_W-1:0]   quality_res,
    output logic [rpam_pkg::RUN_W-1:0]    run_count,
    output logic                          last
);

    rpam_pkg::dp_cmd_t    cmd;
    rpam_pkg::dp_status_t status;

    // The enable register can take a write beat in any cycle.
    assign cfg_ready = 1'b1;

    rpam_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .op       (op),
        .status   (status),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    rpam_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .variant_index     (variant_index),
        .allele_code       (allele_code),
        .quality           (quality),
        .cfg_valid         (cfg_valid),
        .cfg_single_reads  (single_reads_enable),
        .out_stall         (out_stall),
        .out_valid         (out_valid),
        .kind              (kind),
        .variant_index_res (variant_index_res),
        .allele_code_res   (allele_code_res),
        .quality_res       (quality_res),
        .run_count         (run_count),
        .last              (last)
    );

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for read_pair_allele_merge_unit: loads read pairs, predicts
// the emitted alleles of every process beat and compares each result beat in order.
// Depends on rpam_pkg and the RTL of the block; it needs no file or argument.

module tb_top;

    localparam logic [rpam_pkg::OP_W-1:0]   OP_UNUSED     = 2'd3;
    localparam logic [rpam_pkg::IDX_W-1:0]  IDX_MAX       = '1;
    localparam logic [rpam_pkg::CODE_W-1:0] BASE_A        = 8'h41;
    localparam logic [rpam_pkg::CODE_W-1:0] BASE_C        = 8'h43;
    localparam logic [rpam_pkg::CODE_W-1:0] BASE_G        = 8'h47;
    localparam logic [rpam_pkg::CODE_W-1:0] BASE_T        = 8'h54;
    localparam int                          SETTLE_CYCLES = 6;
    localparam int                          ITEM_TARGET   = 430;

    typedef enum {ACT_BEAT, ACT_CFG, ACT_DRAIN} action_t;

    typedef struct {
        action_t                   action;
        logic [rpam_pkg::OP_W-1:0] op;
        rpam_pkg::entry_t          allele;
        logic                      enable;
        int                        gap;
    } pending_t;

    typedef struct {
        rpam_pkg::kind_t            kind;
        rpam_pkg::entry_t           allele;
        logic [rpam_pkg::RUN_W-1:0] runs;
        logic                       last;
    } allele_res_t;

    logic                          clk                 = 1'b0;
    logic                          rst_n               = 1'b0;
    logic                          in_valid            = 1'b0;
    logic                          in_stall;
    logic [rpam_pkg::OP_W-1:0]     op                  = '0;
    logic [rpam_pkg::IDX_W-1:0]    variant_index       = '0;
    logic [rpam_pkg::CODE_W-1:0]   allele_code         = '0;
    logic [rpam_pkg::QUAL_W-1:0]   quality             = '0;
    logic                          cfg_valid           = 1'b0;
    logic                          cfg_ready;
    logic                          single_reads_enable = 1'b0;
    logic                          out_valid;
    logic                          out_stall           = 1'b0;
    logic [rpam_pkg::KIND_W-1:0]   kind;
    logic [rpam_pkg::IDX_W-1:0]    variant_index_res;
    logic [rpam_pkg::CODE_W-1:0]   allele_code_res;
    logic [rpam_pkg::QUAL_W-1:0]   quality_res;
    logic [rpam_pkg::RUN_W-1:0]    run_count;
    logic                          last;

    // Predicted state of the block.
    rpam_pkg::entry_t    first_reads [rpam_pkg::MAX_ALLELES];
    rpam_pkg::entry_t    second_reads [rpam_pkg::MAX_ALLELES];
    int                  first_count  = 0;
    int                  second_count = 0;
    logic                enable_model = 1'b0;

    allele_res_t         alleles_due [$];
    pending_t            beats_pending [$];
    int                  beats_added  = 0;
    int                  errors       = 0;
    bit                  sender_calm  = 1'b0;
    int                  gap_left     = 0;
    int                  quiet_cycles = 0;
    int                  stall_left   = 0;
    int                  results_seen = 0;

    always #5 clk = ~clk;

    read_pair_allele_merge_unit u_top (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .op                  (op),
        .variant_index       (variant_index),
        .allele_code         (allele_code),
        .quality             (quality),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .single_reads_enable (single_reads_enable),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .kind                (kind),
        .variant_index_res   (variant_index_res),
        .allele_code_res     (allele_code_res),
        .quality_res         (quality_res),
        .run_count           (run_count),
        .last                (last)
    );

    function automatic rpam_pkg::entry_t mk_allele(logic [rpam_pkg::IDX_W-1:0] idx,
                                                   logic [rpam_pkg::CODE_W-1:0] code,
                                                   logic [rpam_pkg::QUAL_W-1:0] qual);
        return {idx, code, qual};
    endfunction

    // Every allele of one emitted list carries the number of index runs in that list.
    function automatic void queue_alleles(rpam_pkg::entry_t lst[$], rpam_pkg::kind_t k);
        allele_res_t r;
        int          runs;
        runs = 1;
        for (int i = 1; i < lst.size(); i++)
        begin
            if (int'(lst[i].idx) != int'(lst[i-1].idx) + 1)
                runs++;
        end
        for (int i = 0; i < lst.size(); i++)
        begin
            r.kind   = k;
            r.allele = lst[i];
            r.runs   = rpam_pkg::RUN_W'(runs);
            r.last   = (i == lst.size() - 1);
            alleles_due.push_back(r);
        end
    endfunction

    function automatic void queue_none();
        allele_res_t r;
        r.kind   = rpam_pkg::KIND_NONE;
        r.allele = '0;
        r.runs   = '0;
        r.last   = 1'b1;
        alleles_due.push_back(r);
    endfunction

    function automatic void predict_pair();
        rpam_pkg::entry_t firsts [$];
        rpam_pkg::entry_t seconds [$];
        rpam_pkg::entry_t merged [$];
        rpam_pkg::entry_t e;
        int               j;
        int               k;
        for (int i = 0; i < first_count; i++)
            firsts.push_back(first_reads[i]);
        for (int i = 0; i < second_count; i++)
            seconds.push_back(second_reads[i]);
        if (first_count == 0 || second_count == 0)
            queue_none();
        else if (firsts[first_count-1].idx < seconds[0].idx)
        begin
            merged = firsts;
            foreach (seconds[i])
                merged.push_back(seconds[i]);
            queue_alleles(merged, rpam_pkg::KIND_FIRST_SECOND);
        end
        else if (seconds[second_count-1].idx < firsts[0].idx)
        begin
            merged = seconds;
            foreach (firsts[i])
                merged.push_back(firsts[i]);
            queue_alleles(merged, rpam_pkg::KIND_SECOND_FIRST);
        end
        else if (first_count + second_count > 2)
        begin
            j = 0;
            k = 0;
            while (j < first_count || k < second_count)
            begin
                if (j >= first_count)
                begin
                    merged.push_back(seconds[k]);
                    k++;
                end
                else if (k >= second_count || firsts[j].idx < seconds[k].idx)
                begin
                    merged.push_back(firsts[j]);
                    j++;
                end
                else if (firsts[j].idx > seconds[k].idx)
                begin
                    merged.push_back(seconds[k]);
                    k++;
                end
                else
                begin
                    // Same variant seen by both mates: keep it only if they agree.
                    if (firsts[j].code == seconds[k].code)
                    begin
                        e = firsts[j];
                        if (seconds[k].qual > e.qual)
                            e.qual = seconds[k].qual;
                        merged.push_back(e);
                    end
                    j++;
                    k++;
                end
            end
            if (merged.size() >= 2)
                queue_alleles(merged, rpam_pkg::KIND_MERGED);
            else
                queue_none();
        end
        else if (enable_model)
            queue_alleles(firsts, rpam_pkg::KIND_FIRST_ALONE);
        else
            queue_none();
        first_count  = 0;
        second_count = 0;
    endfunction

    function automatic void predict_beat(pending_t beat);
        case (beat.op)
            rpam_pkg::OP_APPEND_FIRST:
            begin
                if (first_count < rpam_pkg::MAX_ALLELES)
                begin
                    first_reads[first_count] = beat.allele;
                    first_count++;
                end
            end
            rpam_pkg::OP_APPEND_SECOND:
            begin
                if (second_count < rpam_pkg::MAX_ALLELES)
                begin
                    second_reads[second_count] = beat.allele;
                    second_count++;
                end
            end
            rpam_pkg::OP_PROCESS: predict_pair();
            default: ;
        endcase
    endfunction

    function automatic void add_beat(logic [rpam_pkg::OP_W-1:0] beat_op,
                                     rpam_pkg::entry_t allele);
        pending_t p;
        p.action = ACT_BEAT;
        p.op     = beat_op;
        p.allele = allele;
        p.enable = 1'b0;
        p.gap    = sender_calm ? 0 : $urandom_range(0, 3);
        beats_pending.push_back(p);
        if (beat_op != OP_UNUSED)
            beats_added++;
    endfunction

    function automatic void add_hold(action_t act, logic enable);
        pending_t p;
        p.action = act;
        p.op     = OP_UNUSED;
        p.allele = '0;
        p.enable = enable;
        p.gap    = 0;
        beats_pending.push_back(p);
    endfunction

    function automatic rpam_pkg::entry_t random_allele(int off);
        logic [rpam_pkg::CODE_W-1:0] c;
        case ($urandom_range(0, 4))
            0: c = BASE_A;
            1: c = BASE_C;
            2: c = BASE_G;
            3: c = BASE_T;
            default: c = rpam_pkg::CODE_W'($urandom());
        endcase
        return mk_allele(rpam_pkg::IDX_W'(off), c, rpam_pkg::QUAL_W'($urandom()));
    endfunction

    function automatic int pick_size();
        int r;
        r = $urandom_range(0, 19);
        if (r < 14)
            return $urandom_range(1, 4);
        if (r < 18)
            return $urandom_range(5, 12);
        if (r < 19)
            return $urandom_range(13, rpam_pkg::MAX_ALLELES);
        return $urandom_range(rpam_pkg::MAX_ALLELES - 2, rpam_pkg::MAX_ALLELES + 2);
    endfunction

    function automatic int pick_step();
        return ($urandom_range(0, 2) == 0) ? 2 : 1;
    endfunction

    // One read pair: mostly well-formed sorted lists in one of the pair classes,
    // sometimes unsorted noise, and now and then no process beat at the end.
    function automatic void add_pair();
        rpam_pkg::entry_t           firsts [$];
        rpam_pkg::entry_t           seconds [$];
        rpam_pkg::entry_t           swap_q [$];
        rpam_pkg::entry_t           e;
        rpam_pkg::entry_t           f;
        int                         shape;
        int                         off;
        int                         side;
        int                         i;
        int                         j;
        logic [rpam_pkg::IDX_W-1:0] base;
        shape       = $urandom_range(0, 9);
        sender_calm = ($urandom_range(0, 3) == 0);
        off         = 0;
        if (shape <= 1)
        begin
            repeat (pick_size())
            begin
                firsts.push_back(random_allele(off));
                off += pick_step();
            end
            off += $urandom_range(0, 2);
            repeat (pick_size())
            begin
                seconds.push_back(random_allele(off));
                off += pick_step();
            end
            if (shape == 1)
            begin
                swap_q  = firsts;
                firsts  = seconds;
                seconds = swap_q;
            end
        end
        else if (shape <= 5)
        begin
            repeat (pick_size())
            begin
                e = random_allele(off);
                case ($urandom_range(0, 2))
                    0: firsts.push_back(e);
                    1: seconds.push_back(e);
                    default:
                    begin
                        f = random_allele(off);
                        if ($urandom_range(0, 2) != 0)
                            f.code = e.code;
                        firsts.push_back(e);
                        seconds.push_back(f);
                    end
                endcase
                off += pick_step();
            end
        end
        else if (shape == 6)
        begin
            e = random_allele(0);
            f = random_allele(0);
            if ($urandom_range(0, 1) == 1)
                f.code = e.code;
            firsts.push_back(e);
            seconds.push_back(f);
            off = 1;
        end
        else if (shape == 7)
        begin
            side = $urandom_range(0, 1);
            repeat (pick_size())
            begin
                if (side == 0)
                    firsts.push_back(random_allele(off));
                else
                    seconds.push_back(random_allele(off));
                off += pick_step();
            end
        end
        else
        begin
            repeat (pick_size())
            begin
                e = random_allele($urandom_range(0, 15));
                if (shape == 8)
                    e.idx = rpam_pkg::IDX_W'($urandom());
                if ($urandom_range(0, 1) == 1)
                    firsts.push_back(e);
                else
                    seconds.push_back(e);
            end
            off = 16;
        end
        if (shape != 8)
        begin
            case ($urandom_range(0, 7))
                0: base = IDX_MAX - rpam_pkg::IDX_W'(off);
                1: base = '0;
                default: base = rpam_pkg::IDX_W'($urandom_range(0, IDX_MAX - off));
            endcase
            foreach (firsts[k])
                firsts[k].idx += base;
            foreach (seconds[k])
                seconds[k].idx += base;
        end
        i = 0;
        j = 0;
        while (i < firsts.size() || j < seconds.size())
        begin
            if (j >= seconds.size() || (i < firsts.size() && $urandom_range(0, 1) == 1))
            begin
                add_beat(rpam_pkg::OP_APPEND_FIRST, firsts[i]);
                i++;
            end
            else
            begin
                add_beat(rpam_pkg::OP_APPEND_SECOND, seconds[j]);
                j++;
            end
            if ($urandom_range(0, 19) == 0)
            begin
                e = random_allele(0);
                e.idx = rpam_pkg::IDX_W'($urandom());
                add_beat(OP_UNUSED, e);
            end
        end
        e = random_allele(0);
        e.idx = rpam_pkg::IDX_W'($urandom());
        if ($urandom_range(0, 24) != 0)
            add_beat(rpam_pkg::OP_PROCESS, e);
    endfunction

    function automatic int head_gap();
        return (beats_pending.size() != 0) ? beats_pending[0].gap : 0;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // Driver: presents pending beats and register writes; the predictor runs on
    // every accepted beat.
    always @(posedge clk or negedge rst_n)
    begin : driver_proc
        logic     next_valid;
        logic     next_cfg;
        pending_t head;
        if (!rst_n)
        begin
            in_valid     <= 1'b0;
            cfg_valid    <= 1'b0;
            first_count  = 0;
            second_count = 0;
            enable_model = 1'b0;
            gap_left     = 0;
            quiet_cycles = 0;
        end
        else
        begin
            next_valid = in_valid;
            next_cfg   = cfg_valid;
            if (in_valid && !in_stall)
            begin
                predict_beat(beats_pending.pop_front());
                next_valid = 1'b0;
                gap_left   = head_gap();
            end
            if (cfg_valid && cfg_ready)
            begin
                enable_model = single_reads_enable;
                void'(beats_pending.pop_front());
                next_cfg = 1'b0;
                gap_left = head_gap();
            end
            if (alleles_due.size() == 0 && !next_valid && !next_cfg)
                quiet_cycles++;
            else
                quiet_cycles = 0;
            if (!next_valid && !next_cfg)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (beats_pending.size() != 0)
                begin
                    head = beats_pending[0];
                    case (head.action)
                        ACT_BEAT:
                        begin
                            next_valid = 1'b1;
                            op            <= head.op;
                            variant_index <= head.allele.idx;
                            allele_code   <= head.allele.code;
                            quality       <= head.allele.qual;
                        end
                        ACT_CFG:
                        begin
                            // The register only changes while the block is idle.
                            if (quiet_cycles >= SETTLE_CYCLES)
                            begin
                                next_cfg = 1'b1;
                                single_reads_enable <= head.enable;
                            end
                        end
                        default:
                        begin
                            if (quiet_cycles >= SETTLE_CYCLES)
                            begin
                                void'(beats_pending.pop_front());
                                gap_left = head_gap();
                            end
                        end
                    endcase
                end
            end
            in_valid  <= next_valid;
            cfg_valid <= next_cfg;
        end
    end

    // Monitor: stalls the result channel at random and checks every accepted beat.
    always @(posedge clk or negedge rst_n)
    begin : monitor_proc
        allele_res_t want;
        if (!rst_n)
        begin
            out_stall    <= 1'b0;
            stall_left   = $urandom_range(0, 3);
            results_seen = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (alleles_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result beat: expected none, actual kind %0d idx %0h",
                             $time, kind, variant_index_res);
                end
                else
                begin
                    want = alleles_due.pop_front();
                    check_field("kind", want.kind, kind);
                    check_field("variant_index_res", want.allele.idx, variant_index_res);
                    check_field("allele_code_res", want.allele.code, allele_code_res);
                    check_field("quality_res", want.allele.qual, quality_res);
                    check_field("run_count", want.runs, run_count);
                    check_field("last", want.last, last);
                end
                stall_left = ((results_seen % 96) < 24) ? 0 : $urandom_range(0, 3);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin
        int directed_beats;
        add_hold(ACT_CFG, 1'b1);
        // Both reads empty, then an unused op with every field bit set.
        add_beat(rpam_pkg::OP_PROCESS, mk_allele('0, '0, '0));
        add_beat(OP_UNUSED, mk_allele(IDX_MAX, '1, '1));
        // First read ends before the second starts, field extremes on the way.
        add_beat(rpam_pkg::OP_APPEND_FIRST, mk_allele('0, 8'h00, 8'h00));
        add_beat(rpam_pkg::OP_APPEND_FIRST, mk_allele(28'd1, 8'hFF, 8'hFF));
        add_beat(rpam_pkg::OP_APPEND_SECOND, mk_allele(IDX_MAX, BASE_T, 8'h80));
        add_beat(rpam_pkg::OP_PROCESS, mk_allele(IDX_MAX, '1, '1));
        // Second read ends right before the first: one run across the seam.
        add_beat(rpam_pkg::OP_APPEND_SECOND, mk_allele(28'd10, BASE_A, 8'd5));
        add_beat(rpam_pkg::OP_APPEND_FIRST, mk_allele(28'd11, BASE_C, 8'd6));
        add_beat(rpam_pkg::OP_APPEND_FIRST, mk_allele(28'd12, BASE_G, 8'd7));
        add_beat(rpam_pkg::OP_PROCESS, mk_allele('0, '0, '0));
        // Overlap: agreeing allele keeps the higher quality, conflicting one is dropped.
        add_beat(rpam_pkg::OP_APPEND_FIRST, mk_allele(28'd100, BASE_A, 8'd30));
        add_beat(rpam_pkg::OP_APPEND_FIRST, mk_allele(28'd101, BASE_C, 8'd40));
        add_beat(rpam_pkg::OP_APPEND_FIRST, mk_allele(28'd103, BASE_G, 8'd50));
        add_beat(rpam_pkg::OP_APPEND_SECOND, mk_allele(28'd101, BASE_C, 8'd60));
        add_beat(rpam_pkg::OP_APPEND_SECOND, mk_allele(28'd103, BASE_T, 8'd10));
        add_beat(rpam_pkg::OP_PROCESS, mk_allele('0, '0, '0));
        // Overlapping pair of two alleles with single reads enabled.
        add_beat(rpam_pkg::OP_APPEND_FIRST, mk_allele(28'd500, BASE_A, 8'd1));
        add_beat(rpam_pkg::OP_APPEND_SECOND, mk_allele(28'd500, BASE_C, 8'd2));
        add_beat(rpam_pkg::OP_PROCESS, mk_allele('0, '0, '0));
        // Second read empty.
        add_beat(rpam_pkg::OP_APPEND_FIRST, mk_allele(28'd7, BASE_G, 8'd9));
        add_beat(rpam_pkg::OP_PROCESS, mk_allele('0, '0, '0));
        // Merge that leaves a single allele.
        add_beat(rpam_pkg::OP_APPEND_FIRST, mk_allele(28'd20, BASE_A, 8'd3));
        add_beat(rpam_pkg::OP_APPEND_FIRST, mk_allele(28'd21, BASE_C, 8'd4));
        add_beat(rpam_pkg::OP_APPEND_SECOND, mk_allele(28'd20, BASE_C, 8'd8));
        add_beat(rpam_pkg::OP_PROCESS, mk_allele('0, '0, '0));
        add_hold(ACT_CFG, 1'b0);
        add_beat(rpam_pkg::OP_APPEND_FIRST, mk_allele(28'd600, BASE_T, 8'd11));
        add_beat(rpam_pkg::OP_APPEND_SECOND, mk_allele(28'd600, BASE_T, 8'd12));
        add_beat(rpam_pkg::OP_PROCESS, mk_allele('0, '0, '0));
        directed_beats = beats_added;

        for (int phase = 0; phase < 4; phase++)
        begin
            add_hold(ACT_CFG, (phase % 2) == 0);
            while (beats_added < directed_beats
                                 + (phase + 1) * ((ITEM_TARGET - directed_beats) / 4))
            begin
                add_pair();
                if ($urandom_range(0, 11) == 0)
                    add_hold(ACT_DRAIN, 1'b0);
            end
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (beats_pending.size() != 0 || in_valid || cfg_valid || alleles_due.size() != 0)
            @(posedge clk);
        repeat (4 * SETTLE_CYCLES) @(posedge clk);
        if (errors == 0 && alleles_due.size() == 0)
            $display("** read_pair_allele_merge_unit: PASSED **");
        else
            $display("** read_pair_allele_merge_unit: FAILED **");
        $finish;
    end

    initial
    begin
        #(10_000_000);
        $display("%0t: timeout with %0d beats pending and %0d results due",
                 $time, beats_pending.size(), alleles_due.size());
        $display("** read_pair_allele_merge_unit: FAILED **");
        $finish;
    end

endmodule
